// ===== rtl/plc_pkg.sv =====
// shared types and constants for the password lock controller
package plc_pkg;

  localparam int PASSWORD_DIGITS = 5;
  localparam int IDX_W = (PASSWORD_DIGITS > 1) ? $clog2(PASSWORD_DIGITS) : 1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;
  localparam int FIFO_CW = 4;

  localparam logic [7:0] OPT_OPEN = 8'h2B;  // '+'
  localparam logic [7:0] OPT_NEW = 8'h2D;   // '-'
  localparam logic [1:0] TRIES_BEFORE_ALARM = 2'd2;
  localparam logic [5:0] TICK_MAX = 6'd63;

  localparam logic [2:0] REG_READY_CODE = 3'd0;
  localparam logic [2:0] REG_OPEN_LIMIT = 3'd1;
  localparam logic [2:0] REG_HOLD_LIMIT = 3'd2;
  localparam logic [2:0] REG_CLOSE_LIMIT = 3'd3;
  localparam logic [2:0] REG_ALARM_LIMIT = 3'd4;

  typedef enum logic [2:0] {
    PH_WAIT       = 3'd0,
    PH_NEW_FIRST  = 3'd1,
    PH_NEW_SECOND = 3'd2,
    PH_MAIN       = 3'd3,
    PH_CHECK      = 3'd4,
    PH_DOOR       = 3'd5,
    PH_ALARM      = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_FWD  = 2'd1,
    MOT_REV  = 2'd2
  } motor_t;

  typedef enum logic [3:0] {
    ST_MAIN     = 4'd0,
    ST_ENTER    = 4'd1,
    ST_MATCH    = 4'd2,
    ST_MISMATCH = 4'd3,
    ST_OPENING  = 4'd4,
    ST_OPENED   = 4'd5,
    ST_CLOSING  = 4'd6,
    ST_NEWPASS  = 4'd7,
    ST_ERROR    = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] ready_code;
    logic [5:0] open_limit;
    logic [5:0] hold_limit;
    logic [5:0] close_limit;
    logic [5:0] alarm_limit;
  } cfg_t;

  typedef struct packed {
    status_t status;
    motor_t  motor;
    logic    buzzer;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  typedef struct packed {
    res_t res;
    logic last;
  } fifo_ent_t;

endpackage

// ===== rtl/plc_core.sv =====
// lock controller state machine: one received word per cycle, up to two results
module plc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_valid,
  input  logic               step_func,
  input  logic [7:0]         step_byte,
  input  plc_pkg::cfg_t      cfg,
  output plc_pkg::step_out_t step_out
);

  localparam logic [plc_pkg::IDX_W-1:0] LAST_IDX =
    plc_pkg::IDX_W'(plc_pkg::PASSWORD_DIGITS - 1);

  plc_pkg::phase_t phase_r, phase_nxt;
  plc_pkg::motor_t motor_r, motor_nxt;
  logic [plc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      differs_r, differs_nxt;
  logic [1:0]                failed_r, failed_nxt;
  logic [5:0]                tick_r, tick_nxt;
  logic [7:0]                chosen_r, chosen_nxt;
  logic                      buzzer_r, buzzer_nxt;

  logic [7:0] entry_r [plc_pkg::PASSWORD_DIGITS];
  logic [7:0] saved_r [plc_pkg::PASSWORD_DIGITS];
  logic       entry_we;
  logic       save_all;

  // shared conditions
  logic [plc_pkg::IDX_W-1:0] cur_idx;
  logic                      last_dig;
  logic [6:0]                tick_inc;
  logic                      door_hit;
  logic                      alarm_hit;
  logic                      differs_now;
  logic                      diff_any;
  logic                      timed_phase;

  always_comb begin
    cur_idx = (32'(idx_r) < plc_pkg::PASSWORD_DIGITS) ? idx_r : '0;
    last_dig = (cur_idx == LAST_IDX);
    tick_inc = {1'b0, tick_r} + 7'd1;
    timed_phase = (phase_r == plc_pkg::PH_DOOR) || (phase_r == plc_pkg::PH_ALARM);
    case (motor_r)
      plc_pkg::MOT_FWD:  door_hit = tick_inc > {1'b0, cfg.open_limit};
      plc_pkg::MOT_STOP: door_hit = tick_inc > {1'b0, cfg.hold_limit};
      default:           door_hit = tick_inc > {1'b0, cfg.close_limit};
    endcase
    alarm_hit = tick_inc > {1'b0, cfg.alarm_limit};
    if (phase_r == plc_pkg::PH_CHECK) begin
      differs_now = saved_r[cur_idx] != step_byte;
    end else begin
      differs_now = entry_r[cur_idx] != step_byte;
    end
    diff_any = differs_r | differs_now;
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    motor_nxt   = motor_r;
    idx_nxt     = idx_r;
    differs_nxt = differs_r;
    failed_nxt  = failed_r;
    tick_nxt    = tick_r;
    chosen_nxt  = chosen_r;
    buzzer_nxt  = buzzer_r;
    entry_we    = 1'b0;
    save_all    = 1'b0;
    if (step_valid && step_func) begin
      if (timed_phase) begin
        tick_nxt = tick_inc[6] ? plc_pkg::TICK_MAX : tick_inc[5:0];
        if (phase_r == plc_pkg::PH_DOOR) begin
          if (door_hit) begin
            case (motor_r)
              plc_pkg::MOT_FWD:  motor_nxt = plc_pkg::MOT_STOP;
              plc_pkg::MOT_STOP: motor_nxt = plc_pkg::MOT_REV;
              default: begin
                motor_nxt = plc_pkg::MOT_STOP;
                tick_nxt  = '0;
                phase_nxt = plc_pkg::PH_MAIN;
              end
            endcase
          end
        end else if (alarm_hit) begin
          buzzer_nxt = 1'b0;
          tick_nxt   = '0;
          failed_nxt = '0;
          phase_nxt  = plc_pkg::PH_MAIN;
        end
      end
    end else if (step_valid) begin
      case (phase_r)
        plc_pkg::PH_WAIT: begin
          if (step_byte == cfg.ready_code) begin
            phase_nxt = plc_pkg::PH_NEW_FIRST;
            idx_nxt   = '0;
          end
        end
        plc_pkg::PH_NEW_FIRST: begin
          entry_we = 1'b1;
          idx_nxt  = cur_idx + 1'b1;
          if (last_dig) begin
            idx_nxt     = '0;
            differs_nxt = 1'b0;
            phase_nxt   = plc_pkg::PH_NEW_SECOND;
          end
        end
        plc_pkg::PH_NEW_SECOND: begin
          differs_nxt = diff_any;
          idx_nxt     = cur_idx + 1'b1;
          if (last_dig) begin
            idx_nxt     = '0;
            differs_nxt = 1'b0;
            if (diff_any) begin
              phase_nxt = plc_pkg::PH_NEW_FIRST;
            end else begin
              save_all  = 1'b1;
              phase_nxt = plc_pkg::PH_MAIN;
            end
          end
        end
        plc_pkg::PH_MAIN: begin
          chosen_nxt  = step_byte;
          idx_nxt     = '0;
          differs_nxt = 1'b0;
          phase_nxt   = plc_pkg::PH_CHECK;
        end
        plc_pkg::PH_CHECK: begin
          entry_we    = 1'b1;
          differs_nxt = diff_any;
          idx_nxt     = cur_idx + 1'b1;
          if (last_dig) begin
            idx_nxt     = '0;
            differs_nxt = 1'b0;
            if (diff_any) begin
              if (failed_r < plc_pkg::TRIES_BEFORE_ALARM) begin
                failed_nxt = failed_r + 2'd1;
              end else begin
                buzzer_nxt = 1'b1;
                tick_nxt   = '0;
                phase_nxt  = plc_pkg::PH_ALARM;
              end
            end else begin
              failed_nxt = '0;
              if (chosen_r == plc_pkg::OPT_OPEN) begin
                motor_nxt = plc_pkg::MOT_FWD;
                tick_nxt  = '0;
                phase_nxt = plc_pkg::PH_DOOR;
              end else if (chosen_r == plc_pkg::OPT_NEW) begin
                phase_nxt = plc_pkg::PH_NEW_FIRST;
              end else begin
                phase_nxt = plc_pkg::PH_MAIN;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // results: the first of a pair carries the levels before the step
  plc_pkg::status_t code0, code1;
  logic [1:0]       cnt;

  always_comb begin
    cnt   = 2'd0;
    code0 = plc_pkg::ST_MAIN;
    code1 = plc_pkg::ST_MAIN;
    if (step_valid && step_func) begin
      if (phase_r == plc_pkg::PH_DOOR && door_hit) begin
        cnt = 2'd1;
        case (motor_r)
          plc_pkg::MOT_FWD:  code0 = plc_pkg::ST_OPENED;
          plc_pkg::MOT_STOP: code0 = plc_pkg::ST_CLOSING;
          default:           code0 = plc_pkg::ST_MAIN;
        endcase
      end else if (phase_r == plc_pkg::PH_ALARM && alarm_hit) begin
        cnt   = 2'd1;
        code0 = plc_pkg::ST_MAIN;
      end
    end else if (step_valid) begin
      case (phase_r)
        plc_pkg::PH_NEW_SECOND: begin
          if (last_dig) begin
            if (diff_any) begin
              cnt   = 2'd1;
              code0 = plc_pkg::ST_MISMATCH;
            end else begin
              cnt   = 2'd2;
              code0 = plc_pkg::ST_MATCH;
              code1 = plc_pkg::ST_MAIN;
            end
          end
        end
        plc_pkg::PH_MAIN: begin
          cnt   = 2'd1;
          code0 = plc_pkg::ST_ENTER;
        end
        plc_pkg::PH_CHECK: begin
          if (last_dig) begin
            if (diff_any) begin
              cnt = 2'd1;
              if (failed_r < plc_pkg::TRIES_BEFORE_ALARM) begin
                code0 = plc_pkg::ST_MISMATCH;
              end else begin
                code0 = plc_pkg::ST_ERROR;
              end
            end else begin
              cnt   = 2'd2;
              code0 = plc_pkg::ST_MATCH;
              if (chosen_r == plc_pkg::OPT_OPEN) begin
                code1 = plc_pkg::ST_OPENING;
              end else if (chosen_r == plc_pkg::OPT_NEW) begin
                code1 = plc_pkg::ST_NEWPASS;
              end else begin
                code1 = plc_pkg::ST_MAIN;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    step_out.cnt       = cnt;
    step_out.r0.status = code0;
    step_out.r0.motor  = (cnt == 2'd2) ? motor_r : motor_nxt;
    step_out.r0.buzzer = (cnt == 2'd2) ? buzzer_r : buzzer_nxt;
    step_out.r1.status = code1;
    step_out.r1.motor  = motor_nxt;
    step_out.r1.buzzer = buzzer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= plc_pkg::PH_WAIT;
      motor_r   <= plc_pkg::MOT_STOP;
      idx_r     <= '0;
      differs_r <= 1'b0;
      failed_r  <= '0;
      tick_r    <= '0;
      chosen_r  <= '0;
      buzzer_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      motor_r   <= motor_nxt;
      idx_r     <= idx_nxt;
      differs_r <= differs_nxt;
      failed_r  <= failed_nxt;
      tick_r    <= tick_nxt;
      chosen_r  <= chosen_nxt;
      buzzer_r  <= buzzer_nxt;
    end
  end

  // password stores, written before any read
  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_r[cur_idx] <= step_byte;
    end
    if (save_all) begin
      saved_r <= entry_r;
    end
  end

endmodule

// ===== rtl/plc_res_fifo.sv =====
// result queue taking up to two results per cycle and giving one
module plc_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  plc_pkg::step_out_t push,
  input  logic               pop,
  output logic               out_valid,
  output plc_pkg::fifo_ent_t out_ent,
  output logic [plc_pkg::FIFO_CW-1:0] count
);

  plc_pkg::fifo_ent_t mem_r [plc_pkg::FIFO_DEPTH];
  logic [plc_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [plc_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [plc_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic [plc_pkg::FIFO_AW-1:0] wr_ptr_p1;
  logic                        do_pop;

  assign out_valid = (count_r != '0);
  assign out_ent   = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign do_pop    = pop && out_valid;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + plc_pkg::FIFO_AW'(push.cnt);
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + plc_pkg::FIFO_CW'(push.cnt)
               - plc_pkg::FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (push.cnt)
      2'd1: begin
        mem_r[wr_ptr_r] <= '{res: push.r0, last: 1'b1};
      end
      2'd2: begin
        mem_r[wr_ptr_r]  <= '{res: push.r0, last: 1'b0};
        mem_r[wr_ptr_p1] <= '{res: push.r1, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/password_lock_controller_core.sv =====
// top level of the password lock controller: config registers, input stage, core, result queue
//
// usage
// - input channel in_*: one word per item; in_tuser is the kind (0 received byte,
//   1 one-second tick), in_tdata the received byte; a word is taken when
//   in_tvalid and in_tready are both high
// - result channel out_*: status words with motor and buzzer levels; out_tlast
//   marks the final status that one input word causes (zero to two of them)
// - config channel cfg_*: cfg_index picks the register (ready code, open, hold,
//   close and alarm limits), cfg_data holds the value; cfg_ready is always high,
//   writes belong to idle periods only
// - flow: an accepted word lands in the input register, from which the controller
//   step runs and queues its results; the first result is valid once it sits
//   in the result queue
// - throughput: one input word per cycle while in_tready is high; the output
//   drains one status word per cycle while out_tready is high, from an eight-entry queue
// - stall: in_tready drops only when the queue could not take two more results;
//   queued results stay put while out_tready is low
// - reset: synchronous, active low; the lock waits for the ready code, the
//   motor is stopped, the buzzer off and the queue empty
module password_lock_controller_core (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] func
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] status_code, [5:4] motor_drive, [6] buzzer, [7] zero
  output logic       out_tlast,
  // config channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // config registers
  plc_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_code  <= 8'd16;
      cfg_r.open_limit  <= 6'd15;
      cfg_r.hold_limit  <= 6'd18;
      cfg_r.close_limit <= 6'd33;
      cfg_r.alarm_limit <= 6'd60;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        plc_pkg::REG_READY_CODE:  cfg_r.ready_code  <= cfg_data;
        plc_pkg::REG_OPEN_LIMIT:  cfg_r.open_limit  <= cfg_data[5:0];
        plc_pkg::REG_HOLD_LIMIT:  cfg_r.hold_limit  <= cfg_data[5:0];
        plc_pkg::REG_CLOSE_LIMIT: cfg_r.close_limit <= cfg_data[5:0];
        plc_pkg::REG_ALARM_LIMIT: cfg_r.alarm_limit <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // input register, drained into the core every cycle
  logic       in_valid_r;
  logic       in_func_r;
  logic [7:0] in_byte_r;
  logic       in_accept;

  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_func_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  plc_pkg::step_out_t step_out;

  plc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (in_valid_r),
    .step_func  (in_func_r),
    .step_byte  (in_byte_r),
    .cfg        (cfg_r),
    .step_out   (step_out)
  );

  // result queue
  plc_pkg::fifo_ent_t          head;
  logic [plc_pkg::FIFO_CW-1:0] q_count;
  logic [plc_pkg::FIFO_CW:0]   q_claim;

  plc_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_out),
    .pop       (out_tready),
    .out_valid (out_tvalid),
    .out_ent   (head),
    .count     (q_count)
  );

  // room for this cycle's results plus a full pair from the next word
  assign q_claim   = {1'b0, q_count} + (plc_pkg::FIFO_CW + 1)'(step_out.cnt);
  assign in_tready = q_claim <= (plc_pkg::FIFO_CW + 1)'(plc_pkg::FIFO_DEPTH - 2);

  assign out_tdata = {1'b0, head.res.buzzer, head.res.motor, head.res.status};
  assign out_tlast = head.last;

  // queue never holds more than its depth
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= plc_pkg::FIFO_CW'(plc_pkg::FIFO_DEPTH))
    else $error("result queue over depth");

  // a pair of results always finds room
  a_pair_room : assert property (@(posedge clk) disable iff (!rst_n)
    step_out.cnt == 2'd2 |-> q_count <= plc_pkg::FIFO_CW'(plc_pkg::FIFO_DEPTH - 2))
    else $error("result pair pushed into a full queue");

  // an accepted word lands in the input register as a valid step
  a_accept_step : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_valid_r)
    else $error("accepted word not stepped");

  // an error status always comes with the buzzer on
  a_error_buzz : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:0] == plc_pkg::ST_ERROR) |-> out_tdata[6])
    else $error("error status without buzzer");

endmodule
